### hw/rtl/rrqs_pkg.sv
// ----------------------------------------------------------------------------
// rrqs_pkg: shared types and constants of the round-robin quantum scheduler
// Action and status codes, register map and the queue command and status
// structs passed between the control logic and the ready queue.
// ----------------------------------------------------------------------------
package rrqs_pkg;

  // Action codes of an input item
  localparam logic [1:0] ACT_START      = 2'd0;
  localparam logic [1:0] ACT_ADD        = 2'd1;
  localparam logic [1:0] ACT_RESCHEDULE = 2'd2;
  localparam logic [1:0] ACT_TICK       = 2'd3;

  // Status codes of a result item
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_WAITING = 2'd2;

  // Configuration map
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_QUANTUM_TICKS = 3'd0;

  localparam int unsigned PID_W     = 4;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned RCOUNT_W  = 5;
  localparam logic [TICKS_W-1:0] QUANTUM_RESET = 16'd10;

  typedef logic [PID_W-1:0] pid_t;

  // push alone enqueues, pop alone dequeues, both rotate (tail write, head advance)
  typedef struct packed {
    logic push;
    logic pop;
    pid_t wdata;
  } q_cmd_t;

  // count is the fill level before the command of this cycle
  typedef struct packed {
    logic                  empty;
    logic                  full;
    logic [RCOUNT_W-1:0]   count;
  } q_stat_t;

endpackage

### hw/rtl/rrqs_if.sv
// ----------------------------------------------------------------------------
// rrqs_if: valid/ready channels of the round-robin quantum scheduler
// One interface for action items and one for result items.
// ----------------------------------------------------------------------------
interface rrqs_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  rrqs_pkg::pid_t    proc_id;
  logic              current_running;

  modport source (output valid, output action, output proc_id, output current_running,
                  input ready);
  modport sink   (input valid, input action, input proc_id, input current_running,
                  output ready);
endinterface

interface rrqs_out_if;
  logic                           valid;
  logic                           ready;
  rrqs_pkg::pid_t                 current_id;
  logic                           switched;
  logic                           quantum_expired;
  logic [1:0]                     status;
  logic [rrqs_pkg::RCOUNT_W-1:0]  ready_count;

  modport source (output valid, output current_id, output switched, output quantum_expired,
                  output status, output ready_count, input ready);
  modport sink   (input valid, input current_id, input switched, input quantum_expired,
                  input status, input ready_count, output ready);
endinterface

### hw/rtl/rrqs_queue.sv
// ----------------------------------------------------------------------------
// rrqs_queue: ready-process FIFO
// Circular buffer in a synchronous memory with head, tail and fill count;
// the head entry is read on request into a registered output.
// ----------------------------------------------------------------------------
module rrqs_queue #(
  parameter int MAX_PROCS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  rrqs_pkg::q_cmd_t  cmd,
  output rrqs_pkg::pid_t    rd_data,
  output rrqs_pkg::q_stat_t stat
);

  localparam int PTR_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(MAX_PROCS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_PROCS);

  rrqs_pkg::pid_t   mem [MAX_PROCS];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    count_next = count;
    if (cmd.push && !cmd.pop) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop && !cmd.push) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == FULL_CNT);
  assign stat.count = rrqs_pkg::RCOUNT_W'(count);

  // Write at the tail, read the head; read data is registered
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= cmd.wdata;
    end
    if (rd_en) begin
      rd_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.push) begin
        tail <= (tail == LAST_SLOT) ? '0 : tail + PTR_W'(1);
      end
      if (cmd.pop) begin
        head <= (head == LAST_SLOT) ? '0 : head + PTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule

### hw/rtl/round_robin_quantum_scheduler.sv
// A result is written to the output register when its action executes; execution
// waits while the output register still holds an untaken result.
// A new action is taken only once the last one has executed, as the queue head
// is first read from the ready-queue memory before the action can execute.
// Reset (synchronous, active high) clears head, tail, count, running id,
// tick counter and waiting mode and loads quantum_ticks with 10.
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler: round-robin scheduler with time quantum
// Keeps a FIFO of ready process ids, the running id and a quantum
// down-counter, and executes start, add-ready, reschedule and tick actions.
// The queue memory is not cleared; its entries are only used after a write.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler #(
  parameter int MAX_PROCS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  rrqs_in_if.sink                            in_ch,
  rrqs_out_if.source                         out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rrqs_pkg::PADDR_W-1:0]       paddr,
  input  logic [rrqs_pkg::PDATA_W-1:0]       pwdata,
  output logic [rrqs_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  localparam logic S_IDLE = 1'b0;  // waiting for an action
  localparam logic S_EXEC = 1'b1;  // head data ready, execute and write back

  logic                                state;
  logic [1:0]                          act;
  rrqs_pkg::pid_t                      pid;
  logic                                runnable;
  rrqs_pkg::pid_t                      running_id;
  logic [rrqs_pkg::TICKS_W-1:0]        ticks_left;
  logic                                waiting;
  logic [rrqs_pkg::TICKS_W-1:0]        quantum_ticks;

  rrqs_pkg::q_cmd_t                    q_cmd;
  rrqs_pkg::q_stat_t                   q_stat;
  rrqs_pkg::pid_t                      head_id;

  logic                                in_xfer;
  logic                                exec_fire;

  rrqs_pkg::pid_t                      running_id_next;
  logic [rrqs_pkg::TICKS_W-1:0]        ticks_left_next;
  logic                                waiting_next;
  logic                                switched_next;
  logic                                expired_next;
  logic [1:0]                          status_next;
  logic [rrqs_pkg::RCOUNT_W-1:0]       ready_count_next;

  // ---------------------------------------------------------------------------
  // Configuration port: one register, always ready
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_ticks <= rrqs_pkg::QUANTUM_RESET;
    end else if (psel && penable && pwrite && paddr == rrqs_pkg::REG_QUANTUM_TICKS) begin
      quantum_ticks <= pwdata[rrqs_pkg::TICKS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == rrqs_pkg::REG_QUANTUM_TICKS) begin
      prdata = rrqs_pkg::PDATA_W'(quantum_ticks);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: take an action in idle, even while a result still waits; the
  // execute cycle holds until the output register is free.
  // ---------------------------------------------------------------------------
  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign exec_fire   = (state == S_EXEC) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the action; the head read is issued on the same edge
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act      <= in_ch.action;
      pid      <= in_ch.proc_id;
      runnable <= in_ch.current_running;
    end
  end

  rrqs_queue #(
    .MAX_PROCS (MAX_PROCS)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_xfer),
    .cmd     (q_cmd),
    .rd_data (head_id),
    .stat    (q_stat)
  );

  // ---------------------------------------------------------------------------
  // Action execution
  // ---------------------------------------------------------------------------
  always_comb begin
    q_cmd           = '0;
    running_id_next = running_id;
    ticks_left_next = ticks_left;
    waiting_next    = waiting;
    switched_next   = 1'b0;
    expired_next    = 1'b0;
    status_next     = rrqs_pkg::ST_OK;

    case (act)
      rrqs_pkg::ACT_START: begin
        running_id_next = pid;
        ticks_left_next = quantum_ticks;
        waiting_next    = 1'b0;
      end
      rrqs_pkg::ACT_ADD: begin
        if (waiting) begin
          // dispatch directly, queue untouched
          switched_next   = (pid != running_id);
          running_id_next = pid;
          ticks_left_next = quantum_ticks;
          waiting_next    = 1'b0;
        end else if (q_stat.full) begin
          status_next = rrqs_pkg::ST_DROPPED;
        end else begin
          q_cmd.push  = 1'b1;
          q_cmd.wdata = pid;
        end
      end
      rrqs_pkg::ACT_RESCHEDULE: begin
        if (q_stat.empty) begin
          if (runnable) begin
            // keep the same process, reload its quantum
            ticks_left_next = quantum_ticks;
            waiting_next    = 1'b0;
          end else begin
            waiting_next = 1'b1;
            status_next  = rrqs_pkg::ST_WAITING;
          end
        end else begin
          // rotate the runnable process to the tail, dispatch the head
          q_cmd.pop       = 1'b1;
          q_cmd.push      = runnable;
          q_cmd.wdata     = running_id;
          switched_next   = (head_id != running_id);
          running_id_next = head_id;
          ticks_left_next = quantum_ticks;
          waiting_next    = 1'b0;
        end
      end
      rrqs_pkg::ACT_TICK: begin
        ticks_left_next = ticks_left - rrqs_pkg::TICKS_W'(1);
        expired_next    = (ticks_left_next == '0);
      end
      default: begin
        q_cmd = '0;
      end
    endcase

    // only commit in the execute cycle that fires
    if (!exec_fire) begin
      q_cmd = '0;
    end
  end

  // Fill level after the queue command of this cycle
  always_comb begin
    ready_count_next = q_stat.count;
    if (q_cmd.push && !q_cmd.pop) begin
      ready_count_next = q_stat.count + rrqs_pkg::RCOUNT_W'(1);
    end else if (q_cmd.pop && !q_cmd.push) begin
      ready_count_next = q_stat.count - rrqs_pkg::RCOUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_id <= '0;
      ticks_left <= '0;
      waiting    <= 1'b0;
    end else if (exec_fire) begin
      running_id <= running_id_next;
      ticks_left <= ticks_left_next;
      waiting    <= waiting_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (exec_fire) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_ch.current_id      <= running_id_next;
      out_ch.switched        <= switched_next;
      out_ch.quantum_expired <= expired_next;
      out_ch.status          <= status_next;
      out_ch.ready_count     <= ready_count_next;
    end
  end

endmodule

### sim/tb_round_robin_quantum_scheduler.sv
// ----------------------------------------------------------------------------
// tb_round_robin_quantum_scheduler: self-checking bench of the scheduler
// Drives start, add-ready, reschedule and tick actions into the block and
// predicts each result with a cycle-free model of the ready queue, the
// running id, the quantum counter and the waiting mode. A short directed
// sequence covers the corner cases. Randomized bursts that fill, drain and
// tick the queue follow, under several quantum settings and idle/stall mixes,
// plus one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_round_robin_quantum_scheduler;
  import rrqs_pkg::*;

  localparam int QUEUE_DEPTH   = 16;
  // The slowest legal run covers about 1600 actions, plus sender gaps, receiver
  // stalls and one hold-off. Allow many times that.
  localparam int CYCLE_LIMIT   = 200000;
  // Margin for the pipeline to settle after the last result.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    pid_t                current_id;
    logic                switched;
    logic                quantum_expired;
    logic [1:0]          status;
    logic [RCOUNT_W-1:0] ready_count;
  } sched_result_t;

  typedef enum int {
    TRAFFIC_FILL,
    TRAFFIC_DRAIN,
    TRAFFIC_TICKS,
    TRAFFIC_BALANCED
  } traffic_mix_e;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  rrqs_in_if  in_ch ();
  rrqs_out_if out_ch ();

  // Scheduler shadow state, updated once per accepted action
  pid_t                rq_mem [QUEUE_DEPTH];
  logic [3:0]          rq_head;
  logic [3:0]          rq_tail;
  logic [RCOUNT_W-1:0] rq_count;
  pid_t                run_id;
  logic [TICKS_W-1:0]  ticks_left;
  logic [TICKS_W-1:0]  quantum;
  logic                waiting;

  sched_result_t expected_results [$];

  int fail_count       = 0;
  int cycle_count      = 0;
  int send_idle_pct    = 0;
  int recv_stall_pct   = 0;
  int recv_hold_cycles = 0;

  round_robin_quantum_scheduler #(
    .MAX_PROCS (QUEUE_DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction: apply one action to the shadow state and return its result.
  // Queue pointers are 4 bits, so they wrap at the depth of 16 by themselves.
  // --------------------------------------------------------------------------
  function automatic sched_result_t dispatch_action(logic [1:0] act, pid_t pid,
                                                    logic runnable);
    sched_result_t r;
    pid_t          nxt;
    logic          have;
    r = '0;
    case (act)
      ACT_START: begin
        run_id     = pid;
        ticks_left = quantum;
        waiting    = 1'b0;
      end
      ACT_ADD: begin
        if (waiting) begin
          // Dispatch straight away, queue untouched
          r.switched = (pid != run_id);
          run_id     = pid;
          ticks_left = quantum;
          waiting    = 1'b0;
        end else if (rq_count >= QUEUE_DEPTH) begin
          r.status = ST_DROPPED;
        end else begin
          rq_mem[rq_tail] = pid;
          rq_tail++;
          rq_count++;
        end
      end
      ACT_RESCHEDULE: begin
        have = 1'b1;
        nxt  = run_id;
        if (rq_count != 0) begin
          // Read the head before writing the tail: on a full queue they alias
          nxt = rq_mem[rq_head];
          rq_head++;
          if (runnable) begin
            rq_mem[rq_tail] = run_id;
            rq_tail++;
          end else begin
            rq_count--;
          end
        end else if (!runnable) begin
          have = 1'b0;
        end
        if (have) begin
          r.switched = (nxt != run_id);
          run_id     = nxt;
          ticks_left = quantum;
          waiting    = 1'b0;
        end else begin
          // Nothing ready: keep the running id and the counter, wait for an add
          waiting  = 1'b1;
          r.status = ST_WAITING;
        end
      end
      default: begin
        // Tick: 16-bit wrap, counts on while waiting too
        ticks_left        = ticks_left - 1'b1;
        r.quantum_expired = (ticks_left == '0);
      end
    endcase
    r.current_id  = run_id;
    r.ready_count = rq_count;
    return r;
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predict on every input transfer, compare on every output
  // transfer. Both sides are sampled at the rising edge, drives move on the
  // falling edge, so the sampled values are settled.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(dispatch_action(in_ch.action, in_ch.proc_id,
                                                   in_ch.current_running));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: current_id %0d status %0d",
                 out_ch.current_id, out_ch.status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("current_id", 8'(want.current_id), 8'(out_ch.current_id));
          check_field("switched", 8'(want.switched), 8'(out_ch.switched));
          check_field("quantum_expired", 8'(want.quantum_expired),
                      8'(out_ch.quantum_expired));
          check_field("status", 8'(want.status), 8'(out_ch.status));
          check_field("ready_count", 8'(want.ready_count), 8'(out_ch.ready_count));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: stall at random, or hold off entirely while a hold-off
  // count is pending.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        recv_hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one action, idling first at random, and hold it until it transfers.
  // Valid stays high afterwards so back-to-back actions stream without a gap.
  task automatic send_action(input logic [1:0] act, input pid_t pid,
                             input logic runnable);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.action          <= act;
    in_ch.proc_id         <= pid;
    in_ch.current_running <= runnable;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write quantum_ticks over the config port, then read it back.
  // Upper data bits are junk on purpose; only the low 16 bits are kept.
  task automatic set_quantum(input logic [TICKS_W-1:0] value);
    logic [15:0] junk;
    junk = 16'($urandom_range(16'hFFFF));
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_QUANTUM_TICKS;
    pwdata  <= {junk, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    quantum = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    paddr   <= REG_QUANTUM_TICKS;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("quantum_ticks[7:0]", value[7:0], prdata[7:0]);
    check_field("quantum_ticks[15:8]", value[15:8], prdata[15:8]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random actions in bursts of one traffic mix each: fill bursts push the
  // queue to full, drain bursts empty it and fall into waiting mode.
  task automatic run_random_items(input int count);
    traffic_mix_e mix;
    int           burst_left;
    int           roll;
    logic [1:0]   act;
    pid_t         pid;
    logic         runnable;
    mix        = TRAFFIC_BALANCED;
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        mix        = traffic_mix_e'($urandom_range(3));
        burst_left = $urandom_range(40, 10);
      end
      burst_left--;
      roll     = $urandom_range(99);
      pid      = pid_t'($urandom_range(15));
      runnable = 1'($urandom_range(1));
      case (mix)
        TRAFFIC_FILL: begin
          act = (roll < 70) ? ACT_ADD : (roll < 85) ? ACT_TICK :
                (roll < 97) ? ACT_RESCHEDULE : ACT_START;
          // Mostly rotate so the fill level holds
          runnable = ($urandom_range(9) != 0);
        end
        TRAFFIC_DRAIN: begin
          act = (roll < 60) ? ACT_RESCHEDULE : (roll < 75) ? ACT_ADD :
                (roll < 95) ? ACT_TICK : ACT_START;
          runnable = ($urandom_range(9) == 0);
        end
        TRAFFIC_TICKS: begin
          act = (roll < 70) ? ACT_TICK : (roll < 80) ? ACT_ADD :
                (roll < 95) ? ACT_RESCHEDULE : ACT_START;
        end
        default: begin
          act = (roll < 30) ? ACT_ADD : (roll < 60) ? ACT_RESCHEDULE :
                (roll < 90) ? ACT_TICK : ACT_START;
        end
      endcase
      send_action(act, pid, runnable);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner cases straight out of reset, quantum at its reset value
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Tick with the counter at zero: wraps to the top, no expiry
    send_action(ACT_TICK, 4'h0, 1'b0);
    // Nothing ready and not runnable: enter waiting mode
    send_action(ACT_RESCHEDULE, 4'hF, 1'b0);
    // Tick while waiting
    send_action(ACT_TICK, 4'h5, 1'b1);
    // Reschedule while waiting, still runnable, empty queue: keep running
    send_action(ACT_RESCHEDULE, 4'h0, 1'b1);
    send_action(ACT_RESCHEDULE, 4'h0, 1'b0);
    // Add while waiting with the same id: dispatch, no switch
    send_action(ACT_ADD, 4'h0, 1'b0);
    send_action(ACT_RESCHEDULE, 4'h0, 1'b0);
    // Add while waiting with another id: dispatch and switch
    send_action(ACT_ADD, 4'hF, 1'b1);
    send_action(ACT_START, 4'h0, 1'b1);
    // Fill the queue, every id once
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_action(ACT_ADD, pid_t'(i), i[0]);
    end
    // Add to a full queue: dropped
    send_action(ACT_ADD, 4'hA, 1'b0);
    // Rotate a full queue, then pop one
    send_action(ACT_RESCHEDULE, 4'h3, 1'b1);
    send_action(ACT_RESCHEDULE, 4'hC, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [TICKS_W-1:0] quantum_value,
                                     input int count);
    set_quantum(quantum_value);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    run_random_items(count);
    wait_idle();
  endtask

  // Hold the output off for a long stretch while actions keep coming, so the
  // block fills up and stalls its input
  task automatic test_backpressure_fill();
    set_quantum(TICKS_W'($urandom_range(8)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    recv_hold_cycles = HOLD_OFF_CYCLES;
    run_random_items(60);
    wait_idle();
  endtask

  initial begin
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_ch.valid           = 1'b0;
    in_ch.action          = ACT_START;
    in_ch.proc_id         = '0;
    in_ch.current_running = 1'b0;
    rq_head    = '0;
    rq_tail    = '0;
    rq_count   = '0;
    run_id     = '0;
    ticks_left = '0;
    waiting    = 1'b0;
    quantum    = QUANTUM_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_traffic(0, 0, 16'd1, 380);
    test_random_traffic(65, 0, 16'd0, 380);
    test_random_traffic(0, 65, 16'hFFFF, 380);
    test_random_traffic(35, 35, 16'd3, 380);
    test_backpressure_fill();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/rrqs_pkg.sv
hw/rtl/rrqs_if.sv
hw/rtl/rrqs_queue.sv
hw/rtl/round_robin_quantum_scheduler.sv
sim/tb_round_robin_quantum_scheduler.sv
